// ===== src/neighbor_table_with_aging_defines.svh =====
// Assertion macros used by the table back end.
`ifndef NEIGHBOR_TABLE_WITH_AGING_DEFINES_SVH
`define NEIGHBOR_TABLE_WITH_AGING_DEFINES_SVH

`ifndef SYNTHESIS
`define NTA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NTA_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define NTA_ASSERT(lbl, clk, rst_n, prop, msg)
`define NTA_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== src/nta_pkg.sv =====
package nta_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int KEY_WIDTH_DEF   = 32;

	localparam logic [4:0]  MAX_ENTRIES_RST = 5'd16;
	localparam logic [31:0] AGE_LIMIT_RST   = 32'd1000;

	localparam logic CFG_MAX_ENTRIES = 1'b0;
	localparam logic CFG_AGE_LIMIT   = 1'b1;

	typedef enum logic [1:0] {
		OP_ADD     = 2'd0,
		OP_REFRESH = 2'd1,
		OP_LOOKUP  = 2'd2,
		OP_SWEEP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FOUND  = 2'd1,
		ST_ABSENT = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_SCAN,
		BS_FINISH
	} bstate_t;

	// One request as it travels from the front to the back. The key is
	// already masked to the configured key width.
	typedef struct packed {
		op_t         op;
		logic [31:0] key;
		logic [31:0] now;
	} req_t;

endpackage

// ===== src/nta_front.sv =====
module nta_front #(
	parameter int KEY_WIDTH = nta_pkg::KEY_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    action,
	input  logic [31:0]   node_key,
	input  logic [31:0]   current_time,
	input  logic          q_full,
	output logic          busy,
	output logic          push,
	output nta_pkg::req_t push_req
);

	localparam logic [31:0] KEY_MASK = (KEY_WIDTH >= 32) ? 32'hFFFF_FFFF :
		((32'd1 << KEY_WIDTH) - 32'd1);

	logic          vld_s1;
	nta_pkg::req_t req_s1;
	logic          accept;

	// The holding stage only refuses a new request when it is full and
	// the queue cannot take its current one.
	assign push     = vld_s1 && !q_full;
	assign busy     = vld_s1 && q_full;
	assign accept   = start && !busy;
	assign push_req = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.op  <= nta_pkg::op_t'(action);
			req_s1.key <= node_key & KEY_MASK;
			req_s1.now <= current_time;
		end
	end

endmodule

// ===== src/nta_queue.sv =====
module nta_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  nta_pkg::req_t push_req,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output nta_pkg::req_t pop_req
);

	nta_pkg::req_t ent_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign pop_req = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_req;
		end
	end

endmodule

// ===== src/nta_back.sv =====
`include "neighbor_table_with_aging_defines.svh"

module nta_back #(
	parameter int TABLE_DEPTH = nta_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_WIDTH   = nta_pkg::KEY_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  nta_pkg::req_t q_req,
	input  logic [4:0]    max_entries,
	input  logic [31:0]   age_limit,
	output logic          pop,
	output logic          done,
	output logic [1:0]    status,
	output logic [31:0]   arrival_time,
	output logic [4:0]    removed_count,
	output logic [4:0]    neighbor_count
);

	localparam int SKW  = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
	localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int LIMW = (CW > 5) ? CW : 5;
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

	nta_pkg::bstate_t state_q, state_d;
	nta_pkg::req_t    op_q;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          removed_q;

	logic [IW-1:0] idx_q;
	logic          iss_q;
	logic          chk_vld_q;
	logic [IW-1:0] chk_idx_q;

	logic          found_q;
	logic [IW-1:0] found_idx_q;
	logic [31:0]   found_time_q;
	logic          free_q;
	logic [IW-1:0] free_idx_q;

	logic [SKW-1:0] key_mem  [TABLE_DEPTH];
	logic [31:0]    time_mem [TABLE_DEPTH];
	logic [SKW-1:0] rd_key_s1;
	logic [31:0]    rd_time_s1;

	logic            done_q;
	nta_pkg::status_t status_q;
	logic [31:0]     arrival_q;
	logic [4:0]      removed_out_q;
	logic [4:0]      ncount_q;

	// Finish-phase decisions.
	nta_pkg::status_t fin_status;
	logic             fin_key_we;
	logic             fin_time_we;
	logic [IW-1:0]    fin_idx;
	logic             fin_insert;
	logic [31:0]      fin_arrival;

	logic [LIMW-1:0] limit;
	logic            table_full;
	logic            chk_hit;
	logic            chk_stale;
	logic [31:0]     age;

	assign limit = (LIMW'(max_entries) > LIMW'(TABLE_DEPTH)) ? LIMW'(TABLE_DEPTH) :
		LIMW'(max_entries);
	assign table_full = (LIMW'(count_q) >= limit);

	assign age       = op_q.now - rd_time_s1;
	assign chk_hit   = valid_q[chk_idx_q] && (rd_key_s1 == op_q.key[SKW-1:0]);
	assign chk_stale = valid_q[chk_idx_q] && (age > age_limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nta_pkg::BS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		fin_status  = nta_pkg::ST_OK;
		fin_key_we  = 1'b0;
		fin_time_we = 1'b0;
		fin_idx     = found_idx_q;
		fin_insert  = 1'b0;
		fin_arrival = '0;
		case (state_q)
			nta_pkg::BS_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = nta_pkg::BS_SCAN;
				end
			end
			nta_pkg::BS_SCAN: begin
				if (chk_vld_q && chk_idx_q == LAST_IDX) begin
					state_d = nta_pkg::BS_FINISH;
				end
			end
			nta_pkg::BS_FINISH: begin
				state_d = nta_pkg::BS_IDLE;
				case (op_q.op)
					nta_pkg::OP_ADD: begin
						if (table_full) begin
							fin_status = nta_pkg::ST_FULL;
						end else if (found_q) begin
							fin_status  = nta_pkg::ST_FOUND;
							fin_time_we = 1'b1;
						end else if (free_q) begin
							fin_status  = nta_pkg::ST_OK;
							fin_idx     = free_idx_q;
							fin_key_we  = 1'b1;
							fin_time_we = 1'b1;
							fin_insert  = 1'b1;
						end else begin
							fin_status = nta_pkg::ST_FULL;
						end
					end
					nta_pkg::OP_REFRESH: begin
						if (found_q) begin
							fin_status  = nta_pkg::ST_FOUND;
							fin_time_we = 1'b1;
						end else begin
							fin_status = nta_pkg::ST_ABSENT;
						end
					end
					nta_pkg::OP_LOOKUP: begin
						if (found_q) begin
							fin_status  = nta_pkg::ST_FOUND;
							fin_arrival = found_time_q;
						end else begin
							fin_status = nta_pkg::ST_ABSENT;
						end
					end
					default: begin
						fin_status = nta_pkg::ST_OK;
					end
				endcase
			end
			default: begin
				state_d = nta_pkg::BS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			count_q   <= '0;
			removed_q <= '0;
			iss_q     <= 1'b0;
			chk_vld_q <= 1'b0;
			found_q   <= 1'b0;
			free_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				nta_pkg::BS_IDLE: begin
					if (pop) begin
						iss_q     <= 1'b1;
						chk_vld_q <= 1'b0;
						found_q   <= 1'b0;
						free_q    <= 1'b0;
						removed_q <= '0;
					end
				end
				nta_pkg::BS_SCAN: begin
					chk_vld_q <= iss_q;
					if (iss_q && idx_q == LAST_IDX) begin
						iss_q <= 1'b0;
					end
					if (chk_vld_q) begin
						if (op_q.op == nta_pkg::OP_SWEEP) begin
							if (chk_stale) begin
								valid_q[chk_idx_q] <= 1'b0;
								count_q            <= count_q - CW'(1);
								removed_q          <= removed_q + CW'(1);
							end
						end else begin
							if (chk_hit && !found_q) begin
								found_q <= 1'b1;
							end
							if (!valid_q[chk_idx_q] && !free_q) begin
								free_q <= 1'b1;
							end
						end
					end
				end
				nta_pkg::BS_FINISH: begin
					done_q <= 1'b1;
					if (fin_insert) begin
						valid_q[fin_idx] <= 1'b1;
						count_q          <= count_q + CW'(1);
					end
				end
				default: begin
					iss_q <= 1'b0;
				end
			endcase
		end
	end

	// Payload side of the scan and the result registers.
	always_ff @(posedge clk) begin
		if (state_q == nta_pkg::BS_IDLE && pop) begin
			op_q  <= q_req;
			idx_q <= '0;
		end
		if (state_q == nta_pkg::BS_SCAN) begin
			chk_idx_q <= idx_q;
			if (iss_q && idx_q != LAST_IDX) begin
				idx_q <= idx_q + IW'(1);
			end
			if (chk_vld_q && chk_hit && !found_q) begin
				found_idx_q  <= chk_idx_q;
				found_time_q <= rd_time_s1;
			end
			if (chk_vld_q && !valid_q[chk_idx_q] && !free_q) begin
				free_idx_q <= chk_idx_q;
			end
		end
		if (state_q == nta_pkg::BS_FINISH) begin
			status_q      <= fin_status;
			arrival_q     <= fin_arrival;
			removed_out_q <= (op_q.op == nta_pkg::OP_SWEEP) ? 5'(removed_q) : 5'd0;
			ncount_q      <= fin_insert ? 5'(count_q + CW'(1)) : 5'(count_q);
		end
	end

	always_ff @(posedge clk) begin
		rd_key_s1  <= key_mem[idx_q];
		rd_time_s1 <= time_mem[idx_q];
		if (fin_key_we) begin
			key_mem[fin_idx] <= op_q.key[SKW-1:0];
		end
		if (fin_time_we) begin
			time_mem[fin_idx] <= op_q.now;
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign arrival_time   = arrival_q;
	assign removed_count  = removed_out_q;
	assign neighbor_count = ncount_q;

	`NTA_ASSERT(a_count_tracks_valid, clk, arst_n, $countones(valid_q) == int'(count_q), "entry count differs from valid bits")
	`NTA_ASSERT(a_finish_gives_result, clk, arst_n, (state_q == nta_pkg::BS_FINISH) |=> done_q, "finish without result strobe")
	`NTA_NEVER(a_time_only_on_lookup, clk, arst_n, done_q && arrival_q != '0 && op_q.op != nta_pkg::OP_LOOKUP, "arrival time on a non-lookup request")
	`NTA_NEVER(a_removed_only_on_sweep, clk, arst_n, done_q && removed_out_q != '0 && op_q.op != nta_pkg::OP_SWEEP, "removed count on a non-sweep request")

endmodule

// ===== src/neighbor_table_with_aging.sv =====
// Neighbor table with aging.
// A request is taken at a rising edge with start high and busy low; action
// selects add, refresh, lookup or sweep, with node_key and current_time.
// Registers are written through cfg_we, cfg_index and cfg_wdata at any edge
// with cfg_we high: index 0 is max_entries, index 1 is age_limit. The user
// must see that they are written only while no request is in flight; the
// block itself does not enforce it. Every request gives one result: done
// is high for exactly one cycle with status, arrival_time, removed_count
// and neighbor_count valid in that cycle. The receiver cannot stall, so
// results are never held back. The table back end visits the entries one
// per cycle through a single read port and one comparator, and takes no
// new request from the queue until the one before it is done. A two-entry
// queue and a holding stage let up to three requests wait; busy rises only
// when all of them are full. Reset clears all entries, sets max_entries to
// 16 and age_limit to 1000, and empties the queue; no clearing pass is
// needed.
module neighbor_table_with_aging #(
	parameter int TABLE_DEPTH = nta_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_WIDTH   = nta_pkg::KEY_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [31:0] node_key,
	input  logic [31:0] current_time,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] arrival_time,
	output logic [4:0]  removed_count,
	output logic [4:0]  neighbor_count
);

	logic [4:0]  max_entries_q;
	logic [31:0] age_limit_q;

	logic          push;
	nta_pkg::req_t push_req;
	logic          q_full;
	logic          q_empty;
	logic          pop;
	nta_pkg::req_t pop_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= nta_pkg::MAX_ENTRIES_RST;
			age_limit_q   <= nta_pkg::AGE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				nta_pkg::CFG_MAX_ENTRIES: max_entries_q <= cfg_wdata[4:0];
				nta_pkg::CFG_AGE_LIMIT:   age_limit_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	nta_front #(
		.KEY_WIDTH(KEY_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.action      (action),
		.node_key    (node_key),
		.current_time(current_time),
		.q_full      (q_full),
		.busy        (busy),
		.push        (push),
		.push_req    (push_req)
	);

	nta_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_req(push_req),
		.pop     (pop),
		.full    (q_full),
		.empty   (q_empty),
		.pop_req (pop_req)
	);

	nta_back #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_WIDTH  (KEY_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_req         (pop_req),
		.max_entries   (max_entries_q),
		.age_limit     (age_limit_q),
		.pop           (pop),
		.done          (done),
		.status        (status),
		.arrival_time  (arrival_time),
		.removed_count (removed_count),
		.neighbor_count(neighbor_count)
	);

endmodule
